FILE: sv/psp_pkg.sv
// Package for the printf conversion spec parser: payload structs, control
// state struct, character constants and default parameter values.
// No dependencies.
package psp_pkg;

    localparam int NUM_BITS_DEF = 16;
    localparam int LEN_BITS_DEF = 8;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;

    // Bit positions inside the flag vector.
    localparam int FB_MINUS = 0;
    localparam int FB_ZERO  = 1;
    localparam int FB_HASH  = 2;
    localparam int FB_SPACE = 3;
    localparam int FB_PLUS  = 4;
    localparam int FB_DOT   = 5;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } in_t;

    typedef struct packed {
        logic        flag_minus;
        logic        flag_zero;
        logic        flag_hash;
        logic        flag_space;
        logic        flag_plus;
        logic        has_dot;
        logic [15:0] width;
        logic [15:0] precision;
        logic [7:0]  conversion;
        logic        valid_res;
        logic [7:0]  consumed_length;
    } out_t;

    typedef struct packed {
        logic [5:0] flag_bits;
        logic       prev_was_digit;
        logic       width_closed;
        logic       bad_flag;
    } ctl_t;

endpackage

FILE: sv/psp_step.sv
// Combinational per-character update of the spec parser state and the
// result built when a conversion letter arrives. Depends on psp_pkg.
module psp_step #(
    parameter int NUM_BITS = psp_pkg::NUM_BITS_DEF,
    parameter int LEN_BITS = psp_pkg::LEN_BITS_DEF
) (
    input  psp_pkg::in_t          item,
    input  psp_pkg::ctl_t         ctl,
    input  logic [NUM_BITS-1:0]   width_acc,
    input  logic [NUM_BITS-1:0]   precision_acc,
    input  logic [LEN_BITS-1:0]   char_count,
    output psp_pkg::ctl_t         ctl_next,
    output logic [NUM_BITS-1:0]   width_next,
    output logic [NUM_BITS-1:0]   precision_next,
    output logic [LEN_BITS-1:0]   count_next,
    output logic                  emit,
    output psp_pkg::out_t         result
);

    localparam logic [NUM_BITS-1:0] NUM_MAX = '1;
    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

    psp_pkg::ctl_t         ctl_eff;
    logic [NUM_BITS-1:0]   width_eff;
    logic [NUM_BITS-1:0]   prec_eff;
    logic [LEN_BITS-1:0]   count_eff;
    logic                  is_alpha;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [NUM_BITS-1:0]   digit_acc;
    logic [NUM_BITS+3:0]   acc_times10;
    logic [NUM_BITS-1:0]   acc_added;
    logic [LEN_BITS:0]     len_sum;
    logic [LEN_BITS-1:0]   len_sat;
    logic [NUM_BITS+15:0]  width_wide;
    logic [NUM_BITS+15:0]  prec_wide;
    logic [LEN_BITS+7:0]   len_wide;

    // The first character of a spec sees cleared state.
    assign ctl_eff   = item.first ? '0 : ctl;
    assign width_eff = item.first ? '0 : width_acc;
    assign prec_eff  = item.first ? '0 : precision_acc;
    assign count_eff = item.first ? '0 : char_count;

    assign is_alpha = ((item.ch >= psp_pkg::CH_UC_A) && (item.ch <= psp_pkg::CH_UC_Z))
                   || ((item.ch >= psp_pkg::CH_LC_A) && (item.ch <= psp_pkg::CH_LC_Z));
    assign is_digit = (item.ch >= psp_pkg::CH_ZERO) && (item.ch <= psp_pkg::CH_NINE);
    assign digit    = 4'(item.ch - psp_pkg::CH_ZERO);

    // One shared saturating multiply-by-ten-and-add for whichever
    // accumulator the digit goes to.
    assign digit_acc   = ctl_eff.flag_bits[psp_pkg::FB_DOT] ? prec_eff : width_eff;
    assign acc_times10 = ({4'b0, digit_acc} << 3) + ({4'b0, digit_acc} << 1)
                       + {{NUM_BITS{1'b0}}, digit};
    assign acc_added   = (acc_times10 > {4'b0, NUM_MAX}) ? NUM_MAX
                                                         : acc_times10[NUM_BITS-1:0];

    assign len_sum = {1'b0, count_eff} + (LEN_BITS+1)'(2);
    assign len_sat = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];

    assign width_wide = {16'b0, width_eff};
    assign prec_wide  = {16'b0, prec_eff};
    assign len_wide   = {8'b0, len_sat};

    assign emit = is_alpha;

    always_comb
    begin
        result.flag_minus      = ctl_eff.flag_bits[psp_pkg::FB_MINUS];
        result.flag_zero       = ctl_eff.flag_bits[psp_pkg::FB_ZERO];
        result.flag_hash       = ctl_eff.flag_bits[psp_pkg::FB_HASH];
        result.flag_space      = ctl_eff.flag_bits[psp_pkg::FB_SPACE];
        result.flag_plus       = ctl_eff.flag_bits[psp_pkg::FB_PLUS];
        result.has_dot         = ctl_eff.flag_bits[psp_pkg::FB_DOT];
        result.width           = width_wide[15:0];
        result.precision       = prec_wide[15:0];
        result.conversion      = item.ch;
        result.valid_res       = !ctl_eff.bad_flag;
        result.consumed_length = len_wide[7:0];
    end

    always_comb
    begin
        ctl_next       = ctl_eff;
        width_next     = width_eff;
        precision_next = prec_eff;
        count_next     = (count_eff != LEN_MAX) ? count_eff + 1'b1 : count_eff;
        if (is_alpha)
        begin
            // The letter ends the spec and everything returns to reset.
            ctl_next       = '0;
            width_next     = '0;
            precision_next = '0;
            count_next     = '0;
        end
        else if (is_digit)
        begin
            if (ctl_eff.flag_bits[psp_pkg::FB_DOT])
            begin
                precision_next = acc_added;
            end
            else if ((item.ch == psp_pkg::CH_ZERO) && !ctl_eff.prev_was_digit)
            begin
                ctl_next.flag_bits[psp_pkg::FB_ZERO] = 1'b1;
            end
            else if (!ctl_eff.width_closed)
            begin
                width_next = acc_added;
            end
            ctl_next.prev_was_digit = 1'b1;
        end
        else
        begin
            if (width_eff != '0)
            begin
                ctl_next.width_closed = 1'b1;
            end
            ctl_next.prev_was_digit = 1'b0;
            unique case (item.ch)
                psp_pkg::CH_MINUS: ctl_next.flag_bits[psp_pkg::FB_MINUS] = 1'b1;
                psp_pkg::CH_HASH:  ctl_next.flag_bits[psp_pkg::FB_HASH]  = 1'b1;
                psp_pkg::CH_SPACE: ctl_next.flag_bits[psp_pkg::FB_SPACE] = 1'b1;
                psp_pkg::CH_PLUS:  ctl_next.flag_bits[psp_pkg::FB_PLUS]  = 1'b1;
                psp_pkg::CH_DOT:
                begin
                    ctl_next.flag_bits[psp_pkg::FB_DOT] = 1'b1;
                    ctl_next.width_closed               = 1'b1;
                end
                default:           ctl_next.bad_flag = 1'b1;
            endcase
        end
    end

endmodule

FILE: sv/printf_spec_parser.sv
// Top level of the printf conversion spec parser: input register, parse
// state registers and result register around psp_step. Depends on psp_pkg.
//
// Usage: characters that follow a '%' are sent one per request on the input
// channel (in_valid/in_ready, payload in_data with ch and first). Set first
// on the character right after the '%'. Every request that carries an ASCII
// letter ends the spec and yields one result request on the output channel
// (out_valid/out_ready, payload out_data); all other characters yield none.
// Throughput is one character per cycle unless a letter waits for the busy
// result register, set by the combinational update of the parse state
// (one compare set plus a multiply by ten and add). A character is held in
// the input register and parsed from there; a letter's result is written to
// the output register as it is parsed and is then offered on out_valid.
// When the receiver stalls, the result waits in the output register;
// characters that produce no result keep being parsed, and the input holds
// off only while a letter waits for the busy result register.
// Reset clears the parse state and both stages' valid bits; the block is
// ready for a first character right after reset is released.
module printf_spec_parser #(
    parameter int NUM_BITS = psp_pkg::NUM_BITS_DEF,
    parameter int LEN_BITS = psp_pkg::LEN_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  psp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output psp_pkg::out_t out_data
);

    logic                 in_valid_reg;
    psp_pkg::in_t         in_data_reg;
    psp_pkg::ctl_t        ctl_reg;
    psp_pkg::ctl_t        ctl_next;
    logic [NUM_BITS-1:0]  width_reg;
    logic [NUM_BITS-1:0]  width_next;
    logic [NUM_BITS-1:0]  precision_reg;
    logic [NUM_BITS-1:0]  precision_next;
    logic [LEN_BITS-1:0]  count_reg;
    logic [LEN_BITS-1:0]  count_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    psp_pkg::out_t        out_data_reg;
    logic                 emit;
    psp_pkg::out_t        result;
    logic                 proc_fire;

    psp_step #(
        .NUM_BITS (NUM_BITS),
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .item           (in_data_reg),
        .ctl            (ctl_reg),
        .width_acc      (width_reg),
        .precision_acc  (precision_reg),
        .char_count     (count_reg),
        .ctl_next       (ctl_next),
        .width_next     (width_next),
        .precision_next (precision_next),
        .count_next     (count_next),
        .emit           (emit),
        .result         (result)
    );

    // A held character is parsed unless it is a letter and the result
    // register is occupied by a result nobody is taking.
    assign proc_fire = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= '0;
            width_reg     <= '0;
            precision_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (proc_fire)
            begin
                ctl_reg       <= ctl_next;
                width_reg     <= width_next;
                precision_reg <= precision_next;
                count_reg     <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (proc_fire && emit)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/tb_printf_spec_parser.sv
// Testbench for printf_spec_parser: streams format spec characters through the
// input channel and checks every parsed spec against a local predictor.
// Depends on psp_pkg and the printf_spec_parser RTL.
`timescale 1ns / 100ps

module tb_printf_spec_parser;

    import psp_pkg::*;

    localparam int unsigned NUM_MAX     = (1 << NUM_BITS_DEF) - 1;
    localparam int unsigned LEN_MAX     = (1 << LEN_BITS_DEF) - 1;
    localparam int          CHAR_TARGET = 1700;
    localparam int          CYCLE_LIMIT = 100000;
    localparam int          CALM_START  = 1000;
    localparam int          CALM_END    = 2000;
    localparam int          MAX_REPORTS = 10;
    localparam string       FLAG_SET    = "-0# +";

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    in_t  char_q[$];
    out_t spec_exp_q[$];

    // Predictor copy of the parse state.
    logic [5:0]  pred_flags;
    logic [15:0] pred_width;
    logic [15:0] pred_prec;
    logic [7:0]  pred_count;
    logic        pred_prev_digit;
    logic        pred_width_closed;
    logic        pred_bad;

    int cycles        = 0;
    int mismatches    = 0;
    int chars_sent    = 0;
    int specs_checked = 0;
    int invalid_specs = 0;
    int saturated     = 0;
    int long_runs     = 0;
    logic calm;

    printf_spec_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    assign calm = (cycles >= CALM_START) && (cycles < CALM_END);

    function void clear_parse;
        pred_flags        = '0;
        pred_width        = '0;
        pred_prec         = '0;
        pred_count        = '0;
        pred_prev_digit   = 1'b0;
        pred_width_closed = 1'b0;
        pred_bad          = 1'b0;
    endfunction

    function automatic logic [15:0] accum_digit(logic [15:0] acc, logic [7:0] c);
        int unsigned v;
        v = 32'(acc) * 10 + 32'(c) - 32'(CH_ZERO);
        return (v > NUM_MAX) ? NUM_MAX[15:0] : v[15:0];
    endfunction

    function void parse_char(in_t item);
        logic [7:0]  c;
        logic        alpha;
        logic        digit;
        int unsigned len;
        out_t        r;
        c     = item.ch;
        alpha = ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (item.first)
            clear_parse();
        if (alpha)
        begin
            len = 32'(pred_count) + 2;
            if (len > LEN_MAX)
                len = LEN_MAX;
            r.flag_minus      = pred_flags[FB_MINUS];
            r.flag_zero       = pred_flags[FB_ZERO];
            r.flag_hash       = pred_flags[FB_HASH];
            r.flag_space      = pred_flags[FB_SPACE];
            r.flag_plus       = pred_flags[FB_PLUS];
            r.has_dot         = pred_flags[FB_DOT];
            r.width           = pred_width;
            r.precision       = pred_prec;
            r.conversion      = c;
            r.valid_res       = !pred_bad;
            r.consumed_length = len[7:0];
            spec_exp_q.push_back(r);
            clear_parse();
        end
        else
        begin
            if (32'(pred_count) < LEN_MAX)
                pred_count = pred_count + 8'd1;
            if (digit)
            begin
                if (pred_flags[FB_DOT])
                    pred_prec = accum_digit(pred_prec, c);
                else if ((c == CH_ZERO) && !pred_prev_digit)
                    pred_flags[FB_ZERO] = 1'b1;
                else if (!pred_width_closed)
                    pred_width = accum_digit(pred_width, c);
                pred_prev_digit = 1'b1;
            end
            else
            begin
                // Any non-digit ends a nonzero width run.
                if (pred_width != 0)
                    pred_width_closed = 1'b1;
                pred_prev_digit = 1'b0;
                case (c)
                    CH_MINUS: pred_flags[FB_MINUS] = 1'b1;
                    CH_HASH:  pred_flags[FB_HASH]  = 1'b1;
                    CH_SPACE: pred_flags[FB_SPACE] = 1'b1;
                    CH_PLUS:  pred_flags[FB_PLUS]  = 1'b1;
                    CH_DOT:
                    begin
                        pred_flags[FB_DOT] = 1'b1;
                        pred_width_closed  = 1'b1;
                    end
                    default:  pred_bad = 1'b1;
                endcase
            end
        end
    endfunction

    task push_char(input logic [7:0] c, input logic f);
        in_t item;
        item.ch    = c;
        item.first = f;
        char_q.push_back(item);
    endtask

    task push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i], i == 0);
    endtask

    task add_digits(inout logic [7:0] body[$], input int n);
        int i;
        for (i = 0; i < n; i++)
            body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Mostly well-formed specs with random content; the rest carries stray
    // bytes, a missing letter, a missing first or a first in mid-spec.
    task automatic add_random_spec;
        logic [7:0] body[$];
        int         kind;
        int         n;
        int         i;
        int         mid;
        kind = $urandom_range(0, 99);
        mid  = -1;
        if ((kind == 99) && (long_runs < 4))
        begin
            long_runs++;
            n = $urandom_range(250, 270);
            for (i = 0; i < n; i++)
                body.push_back(FLAG_SET[$urandom_range(0, 4)]);
        end
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++)
            body.push_back(FLAG_SET[$urandom_range(0, 4)]);
        if ($urandom_range(0, 9) < 7)
            add_digits(body, ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8)
                                                         : $urandom_range(1, 3));
        if ($urandom_range(0, 9) < 6)
        begin
            body.push_back(CH_DOT);
            add_digits(body, ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8)
                                                         : $urandom_range(0, 3));
        end
        if ((kind >= 85) && (kind < 95))
        begin
            n = $urandom_range(1, 2);
            for (i = 0; i < n; i++)
                body.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1)
                add_digits(body, $urandom_range(1, 2));
        end
        if (kind != 98)
        begin
            if ($urandom_range(0, 1) == 1)
                body.push_back(8'(CH_UC_A + $urandom_range(0, 25)));
            else
                body.push_back(8'(CH_LC_A + $urandom_range(0, 25)));
        end
        if ((kind >= 95) && (kind < 98) && (body.size() > 1))
            mid = $urandom_range(1, body.size() - 1);
        for (i = 0; i < body.size(); i++)
            push_char(body[i], ((i == 0) && (kind < 85)) || (i == mid));
    endtask

    // Request driver: a new request is offered only once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if ((char_q.size() > 0) && (calm || ($urandom_range(0, 99) >= 15)))
            begin
                in_valid <= 1'b1;
                in_data  <= char_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 15);
    end

    // Monitor: predicts on accepted characters, checks accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                parse_char(in_data);
                chars_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (spec_exp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result: conv=%h len=%0d", out_data.conversion,
                                 out_data.consumed_length);
                end
                else
                begin
                    out_t e;
                    e = spec_exp_q.pop_front();
                    specs_checked++;
                    if (!out_data.valid_res)
                        invalid_specs++;
                    if ((out_data.width == NUM_MAX[15:0]) || (out_data.precision == NUM_MAX[15:0])
                        || (out_data.consumed_length == LEN_MAX[7:0]))
                        saturated++;
                    if ((out_data.flag_minus !== e.flag_minus) ||
                        (out_data.flag_zero !== e.flag_zero) ||
                        (out_data.flag_hash !== e.flag_hash) ||
                        (out_data.flag_space !== e.flag_space) ||
                        (out_data.flag_plus !== e.flag_plus) ||
                        (out_data.has_dot !== e.has_dot) ||
                        (out_data.width !== e.width) ||
                        (out_data.precision !== e.precision) ||
                        (out_data.conversion !== e.conversion) ||
                        (out_data.valid_res !== e.valid_res) ||
                        (out_data.consumed_length !== e.consumed_length))
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                        begin
                            $display("Mismatch on spec %0d (flags - 0 # sp +, dot):", specs_checked);
                            $display("  exp: fl=%b%b%b%b%b dot=%b w=%0d p=%0d conv=%h v=%b len=%0d",
                                     e.flag_minus, e.flag_zero, e.flag_hash, e.flag_space,
                                     e.flag_plus, e.has_dot, e.width, e.precision,
                                     e.conversion, e.valid_res, e.consumed_length);
                            $display("  act: fl=%b%b%b%b%b dot=%b w=%0d p=%0d conv=%h v=%b len=%0d",
                                     out_data.flag_minus, out_data.flag_zero, out_data.flag_hash,
                                     out_data.flag_space, out_data.flag_plus, out_data.has_dot,
                                     out_data.width, out_data.precision, out_data.conversion,
                                     out_data.valid_res, out_data.consumed_length);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_parse();
        // Directed: all flags, leading zeros, digits after a second dot,
        // width saturation, non-ASCII and disallowed bytes, letter extremes.
        push_text("-0#+ d");
        push_text("007x");
        push_text("5.3.2f");
        push_text("99999s");
        push_char(8'hFF, 1'b1);
        push_char(8'h00, 1'b0);
        push_char(CH_UC_Z, 1'b0);
        push_char(CH_UC_A, 1'b0);
        push_char(CH_LC_Z, 1'b1);
        while (char_q.size() < CHAR_TARGET)
            add_random_spec();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while ((char_q.size() != 0) || in_valid || (spec_exp_q.size() != 0))
            @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d characters; checked %0d parsed specs, %0d invalid, %0d saturated.",
                 chars_sent, specs_checked, invalid_specs, saturated);
        $display("Mismatches: %0d, results still expected: %0d.", mismatches, spec_exp_q.size());
        if ((mismatches == 0) && (spec_exp_q.size() == 0))
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
